// ===== design/stks_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable two-key record sort: shared package
// Record layout, sizes derived from the store capacity and the sort key.
// ----------------------------------------------------------------------------
package stks_pkg;

   // Capacity of the record store and the widths that follow from it.
   localparam int MAX_RECORDS = 64;
   localparam int IDX_W       = $clog2(MAX_RECORDS);
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

   // Field widths of one record.
   localparam int CHAIN_W = 8;
   localparam int SEQ_W   = 16;
   localparam int TAG_W   = 16;
   localparam int REC_W   = CHAIN_W + SEQ_W + TAG_W;
   localparam int TDATA_W = ((REC_W + 7) / 8) * 8;
   localparam int KEY_W   = CHAIN_W + SEQ_W;

   // One stored record, chain identifier in the lowest bits.
   typedef struct packed {
      logic        [TAG_W-1:0]   record_tag;
      logic signed [SEQ_W-1:0]   seq_number;
      logic        [CHAIN_W-1:0] chain_id;
   } record_type;

   // Combined key: chain above, sequence number with its sign bit inverted
   // below, so that an unsigned compare gives the required order.
   function automatic logic [KEY_W-1:0] sort_key(input record_type rec);
      sort_key = {rec.chain_id, ~rec.seq_number[SEQ_W-1], rec.seq_number[SEQ_W-2:0]};
   endfunction

endpackage

// ===== design/stks_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module stks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/stable_two_key_record_sort_unit.sv =====
// ----------------------------------------------------------------------------
// Stable two-key record sort unit
// Collects records, sorts them by chain identifier and sequence number in
// place in a RAM, and streams the sorted set out.
// ----------------------------------------------------------------------------
// Records are loaded one per cycle into a 64-entry RAM. The transaction
// flagged with tlast closes the set; the unit then stops taking input,
// insertion-sorts the set in place (stable, ascending by chain identifier,
// then by signed sequence number) and emits every record, tlast on the final
// one and tuser set on all of them when records were dropped because the
// store was full. The sort is bounded by the single read and write port of
// the RAM: each record is read and held, then compared with its left
// neighbours one at a time, each larger one moving up a place, until it is
// written where it settles. On output each record is read and then
// offered, and the next is read only once it has been taken. Input is
// taken again the cycle after the final result transaction.
module stable_two_key_record_sort_unit (
   input  logic                         clock,
   input  logic                         reset,
   // Input records.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [stks_pkg::TDATA_W-1:0] req_tdata,   // chain_id, seq_number, record_tag
   input  logic                         req_tlast,   // last_record
   // Sorted records.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [stks_pkg::TDATA_W-1:0] rsp_tdata,   // out_chain_id, out_seq_number, out_tag
   output logic                         rsp_tlast,   // last_out
   output logic                         rsp_tuser    // overflow
);
   import stks_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_LOAD      = 3'd0;
   localparam logic [2:0] ST_SORT_RD   = 3'd1;
   localparam logic [2:0] ST_SORT_GET  = 3'd2;
   localparam logic [2:0] ST_SORT_CMP  = 3'd3;
   localparam logic [2:0] ST_SORT_PUT  = 3'd4;
   localparam logic [2:0] ST_EMIT_RD   = 3'd5;
   localparam logic [2:0] ST_EMIT_SHOW = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [CNT_W-1:0] outer_ff, outer_in;
   logic [IDX_W-1:0] inner_ff, inner_in;
   logic [IDX_W-1:0] emit_ff, emit_in;
   record_type       held_ff, held_in;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   record_type       ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [REC_W-1:0] ram_rd_data;
   record_type       rd_rec;
   record_type       in_rec;
   logic             req_fire;
   logic             rsp_fire;
   logic             emit_final;

   assign in_rec     = record_type'(req_tdata[REC_W-1:0]);
   assign rd_rec     = record_type'(ram_rd_data);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign emit_final = ((CNT_W'(emit_ff) + CNT_W'(1)) == count_ff);

   // Record store.
   stks_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer: load, in-place insertion sort, emit.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      outer_in    = outer_ff;
      inner_in    = inner_ff;
      emit_in     = emit_ff;
      held_in     = held_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[IDX_W-1:0];
      ram_wr_data = in_rec;
      ram_rd_addr = emit_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CNT_W'(MAX_RECORDS)) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_tlast) begin
                  outer_in = CNT_W'(1);
                  state_in = ST_SORT_RD;
               end
            end
         end
         ST_SORT_RD: begin
            // Fetch the next record to insert, or finish.
            if (outer_ff >= count_ff) begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               ram_rd_addr = outer_ff[IDX_W-1:0];
               state_in    = ST_SORT_GET;
            end
         end
         ST_SORT_GET: begin
            // Hold the record and fetch its left neighbour.
            held_in     = rd_rec;
            inner_in    = outer_ff[IDX_W-1:0];
            ram_rd_addr = outer_ff[IDX_W-1:0] - IDX_W'(1);
            state_in    = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = inner_ff;
            if (sort_key(rd_rec) > sort_key(held_ff)) begin
               // Move the larger neighbour up one place and keep going.
               ram_wr_data = rd_rec;
               inner_in    = inner_ff - IDX_W'(1);
               if (inner_ff == IDX_W'(1)) begin
                  state_in = ST_SORT_PUT;
               end else begin
                  ram_rd_addr = inner_ff - IDX_W'(2);
               end
            end else begin
               // Equal or smaller neighbour: the held record settles here.
               ram_wr_data = held_ff;
               outer_in    = outer_ff + CNT_W'(1);
               state_in    = ST_SORT_RD;
            end
         end
         ST_SORT_PUT: begin
            // The held record is the smallest so far.
            ram_wr_en   = 1'b1;
            ram_wr_addr = inner_ff;
            ram_wr_data = held_ff;
            outer_in    = outer_ff + CNT_W'(1);
            state_in    = ST_SORT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_SHOW;
         end
         ST_EMIT_SHOW: begin
            // The read address stays put, so the read data holds while stalled.
            if (rsp_fire) begin
               if (emit_final) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  emit_in  = emit_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         outer_ff    <= '0;
         inner_ff    <= '0;
         emit_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         outer_ff    <= outer_in;
         inner_ff    <= inner_in;
         emit_ff     <= emit_in;
      end
   end

   // Record being inserted.
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   // Ports.
   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_EMIT_SHOW);
   assign rsp_tdata  = TDATA_W'(ram_rd_data);
   assign rsp_tlast  = emit_final;
   assign rsp_tuser  = overflow_ff;

endmodule

// ===== design/stks_checker.sv =====
// ----------------------------------------------------------------------------
// Stable two-key record sort: port checker
// Watches the top-level ports for load/emit phasing and output stability.
// ----------------------------------------------------------------------------
module stks_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [stks_pkg::TDATA_W-1:0] req_tdata,
   input logic                         req_tlast,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [stks_pkg::TDATA_W-1:0] rsp_tdata,
   input logic                         rsp_tlast,
   input logic                         rsp_tuser
);
   import stks_pkg::*;

   // Loading and emitting never overlap.
   a_phase_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is offered");

   // No result straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // The closing record starts the sort, so input stops.
   a_close_stops_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still taken after the closing record");

   // The final result hands back to loading.
   a_final_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("loading not resumed after the final result");

   // A stalled result holds.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind stable_two_key_record_sort_unit stks_checker u_stks_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== bench/stable_two_key_record_sort_unit_test.sv =====
// ----------------------------------------------------------------------------
// Stable two-key record sort unit: self-checking testbench
// Streams sets of records into the unit. A scoreboard keeps its own copy of
// each set, sorts it stably by chain identifier and then by signed sequence
// number, and compares every emitted record against that order. Directed sets
// cover the field extremes, ties and presorted input. Random sets cover a
// full store, a store that overflows, and many small sets, with random gaps
// on both sides and one long stall of the receiver.
// ----------------------------------------------------------------------------
module stable_two_key_record_sort_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import stks_pkg::*;

   localparam int ITEM_TARGET = 270;
   localparam int HOLD_AT     = 40;      // result count at which the long stall starts
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 300000;

   // One expected result transaction: a record and its two flags.
   typedef struct {
      record_type rec;
      bit         last_flag;
      bit         dropped_flag;
   } emitted_record_type;

   // Scoreboard: collects the records of the open set and, when the set is
   // closed, lays out the sorted results that the unit must emit.
   class sort_order_ledger_type;
      record_type         loaded[$];
      bit                 dropped;
      emitted_record_type sorted_due[$];
      int unsigned        mismatches;
      int unsigned        results_checked;
      int unsigned        sets_closed;
      int unsigned        overflow_sets;

      // True when a must come out after b.
      function bit sorts_after(record_type a, record_type b);
         if (a.chain_id != b.chain_id) begin
            return a.chain_id > b.chain_id;
         end
         return $signed(a.seq_number) > $signed(b.seq_number);
      endfunction

      function void note_record(record_type rec, bit closes_set);
         record_type         held;
         emitted_record_type item;
         int                 j;
         if (loaded.size() < MAX_RECORDS) begin
            loaded.push_back(rec);
         end else begin
            dropped = 1'b1;
         end
         if (!closes_set) begin
            return;
         end
         // Insertion sort with a strict compare keeps equal keys in load order.
         for (int i = 1; i < loaded.size(); i++) begin
            held = loaded[i];
            j    = i;
            while (j > 0 && sorts_after(loaded[j-1], held)) begin
               loaded[j] = loaded[j-1];
               j--;
            end
            loaded[j] = held;
         end
         foreach (loaded[k]) begin
            item.rec          = loaded[k];
            item.last_flag    = (k == loaded.size() - 1);
            item.dropped_flag = dropped;
            sorted_due.push_back(item);
         end
         sets_closed++;
         if (dropped) begin
            overflow_sets++;
         end
         loaded.delete();
         dropped = 1'b0;
      endfunction

      function void check_sorted(record_type got, bit got_last, bit got_dropped);
         emitted_record_type want;
         if (sorted_due.size() == 0) begin
            $display("%0t: result with nothing expected, chain %0d seq %0d tag %0d",
                     $time, got.chain_id, $signed(got.seq_number), got.record_tag);
            mismatches++;
            return;
         end
         want = sorted_due.pop_front();
         results_checked++;
         if (got.chain_id !== want.rec.chain_id) begin
            $display("%0t: chain_id mismatch, expected %0d, got %0d",
                     $time, want.rec.chain_id, got.chain_id);
            mismatches++;
         end
         if (got.seq_number !== want.rec.seq_number) begin
            $display("%0t: seq_number mismatch, expected %0d, got %0d",
                     $time, $signed(want.rec.seq_number), $signed(got.seq_number));
            mismatches++;
         end
         if (got.record_tag !== want.rec.record_tag) begin
            $display("%0t: record_tag mismatch, expected %0d, got %0d",
                     $time, want.rec.record_tag, got.record_tag);
            mismatches++;
         end
         if (got_last !== want.last_flag) begin
            $display("%0t: tlast mismatch, expected %0b, got %0b",
                     $time, want.last_flag, got_last);
            mismatches++;
         end
         if (got_dropped !== want.dropped_flag) begin
            $display("%0t: overflow mismatch, expected %0b, got %0b",
                     $time, want.dropped_flag, got_dropped);
            mismatches++;
         end
      endfunction

      function int waiting();
         return sorted_due.size();
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;

   sort_order_ledger_type ledger = new();
   bit                    calm_phase    = 1'b0;
   int unsigned           records_sent  = 0;
   int unsigned           results_taken = 0;
   int unsigned           cycle_count   = 0;

   stable_two_key_record_sort_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic record_type make_record(int chain, int seq, int tag);
      record_type rec;
      rec.chain_id   = chain[CHAIN_W-1:0];
      rec.seq_number = seq[SEQ_W-1:0];
      rec.record_tag = tag[TAG_W-1:0];
      return rec;
   endfunction

   // Narrow keys half of the time so that ties and shared chains are common.
   function automatic record_type random_record();
      record_type rec;
      if ($urandom_range(0, 1) == 0) begin
         rec.chain_id   = CHAIN_W'($urandom_range(0, 3));
         rec.seq_number = SEQ_W'($urandom_range(0, 4) - 2);
      end else begin
         rec.chain_id   = CHAIN_W'($urandom_range(0, 255));
         rec.seq_number = SEQ_W'($urandom_range(0, 65535));
      end
      rec.record_tag = TAG_W'($urandom_range(0, 65535));
      return rec;
   endfunction

   // Offers one record, with an occasional short gap first, and waits for the
   // transaction to complete. Ready is looked at mid-cycle, where it is settled.
   task automatic send_record(record_type rec, bit closes_set);
      bit taken;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rec;
      req_tlast  <= closes_set;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      ledger.note_record(rec, closes_set);
      records_sent++;
   endtask

   task automatic send_set(record_type recs[$]);
      foreach (recs[k]) begin
         send_record(recs[k], k == recs.size() - 1);
      end
   endtask

   task automatic send_random_set(int count);
      for (int k = 0; k < count; k++) begin
         send_record(random_record(), k == count - 1);
      end
   endtask

   // Holds the input back until every expected result has come out.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (ledger.waiting() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   // Result side: checks each completed transaction and paces tready, with
   // short random stalls and one long stall while the sender keeps offering.
   // The outputs are sampled mid-cycle and counted at the following edge.
   initial begin
      int         ready_gap;
      bit         long_hold_done;
      bit         seen_fire;
      record_type seen_rec;
      bit         seen_last;
      bit         seen_user;
      ready_gap      = 0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         seen_fire = rsp_tvalid && rsp_tready;
         seen_rec  = rsp_tdata[REC_W-1:0];
         seen_last = rsp_tlast;
         seen_user = rsp_tuser;
         @(posedge clock);
         if (seen_fire) begin
            ledger.check_sorted(seen_rec, seen_last, seen_user);
            results_taken++;
         end
         if (ready_gap > 0) begin
            ready_gap--;
         end else if (!long_hold_done && results_taken >= HOLD_AT) begin
            long_hold_done = 1'b1;
            ready_gap      = HOLD_CYCLES;
         end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            ready_gap = $urandom_range(1, 3);
         end
         rsp_tready <= (ready_gap == 0);
      end
   end

   // Input side: directed sets, then random sets.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single records at the field extremes.
      send_set('{make_record(0, -32768, 0)});
      send_set('{make_record(255, 32767, 65535)});
      // Mixed order with equal keys that must keep their load order.
      send_set('{make_record(5, 100, 1), make_record(5, -1, 2), make_record(5, 100, 3),
                 make_record(2, 32767, 4), make_record(255, -32768, 5),
                 make_record(2, 32767, 6)});
      // Already in order.
      send_set('{make_record(1, -5, 7), make_record(1, 0, 8), make_record(3, -32768, 9),
                 make_record(200, 32767, 10)});
      // Fully reversed, with sign changes within a chain.
      send_set('{make_record(250, 10, 11), make_record(250, -10, 12),
                 make_record(128, 0, 13), make_record(0, 32767, 14),
                 make_record(0, -32768, 15)});
      // All keys equal: output must be the load order.
      send_set('{make_record(9, -7, 'hA5A5), make_record(9, -7, 'h5A5A),
                 make_record(9, -7, 'hFFFF)});
      wait_for_drain();

      // Store full: two records dropped, the closing one among them.
      send_random_set(MAX_RECORDS + 2);
      // Exactly full, nothing dropped.
      send_random_set(MAX_RECORDS);

      while (records_sent < ITEM_TARGET) begin
         if (records_sent >= ITEM_TARGET - 40) begin
            calm_phase <= 1'b1;
         end
         send_random_set($urandom_range(1, 12));
         if (!calm_phase && $urandom_range(0, 5) == 0) begin
            wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (40) @(posedge clock);

      $display("Sent %0d records in %0d sets, %0d of them with dropped records.",
               records_sent, ledger.sets_closed, ledger.overflow_sets);
      $display("Checked %0d sorted results, %0d mismatches, %0d still outstanding.",
               ledger.results_checked, ledger.mismatches, ledger.waiting());
      if (ledger.mismatches == 0 && ledger.waiting() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
